FILE: src/animation_frame_selector_assert.svh
// ----------------------------------------------------------------------------
// Animation frame selector assertion macros
// Shared property macros for the checker of the animation frame selector.
// ----------------------------------------------------------------------------
`ifndef ANIMATION_FRAME_SELECTOR_ASSERT_SVH
`define ANIMATION_FRAME_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AFS_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// Same-cycle implication, checked at every edge including reset.
`define AFS_ASSERT_ALWAYS(lbl, clk, pre, post, msg) \
   lbl: assert property (@(posedge clk) (pre) |-> (post)) \
      else $error(msg);

`endif

FILE: src/afs_pkg.sv
// ----------------------------------------------------------------------------
// Animation frame selector package
// Field widths, register indexes, transfer payloads and the control
// interface between the controller and the datapath.
// ----------------------------------------------------------------------------
package afs_pkg;

   // Field and register widths.
   localparam int FRAME_COUNT_W = 7;
   localparam int TIME_W        = 32;
   localparam int LOOP_LIMIT_W  = 16;
   localparam int SPEED_W       = 16;
   localparam int SPEED_FRAC_W  = 8;
   localparam int ENTRY_IDX_W   = 6;
   localparam int DUR_W         = 24;
   localparam int FRAME_IDX_W   = 6;
   localparam int PADDR_W       = 4;
   localparam int PDATA_W       = 32;

   // Serial divider: one quotient bit per cycle.
   localparam int DIV_STEPS = TIME_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Request kinds.
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Reset value of the speed register (1.0 in Q8.8).
   localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_FRAME_COUNT    = 2'd0,
      CSR_TOTAL_DURATION = 2'd1,
      CSR_LOOP_LIMIT     = 2'd2,
      CSR_SPEED_Q8       = 2'd3
   } csr_index_type;

   // Input item.
   typedef struct packed {
      logic                   req_type;
      logic [TIME_W-1:0]      now_ms;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [DUR_W-1:0]       entry_duration;
   } req_item_type;

   // Result item.
   typedef struct packed {
      logic [FRAME_IDX_W-1:0] frame_index;
      logic                   frame_changed;
      logic                   animating;
      logic [TIME_W-1:0]      loop_number;
   } rsp_item_type;

   // Configuration registers.
   typedef struct packed {
      logic [FRAME_COUNT_W-1:0] frame_count;
      logic [TIME_W-1:0]        total_duration;
      logic [LOOP_LIMIT_W-1:0]  loop_limit;
      logic [SPEED_W-1:0]       speed_q8;
   } cfg_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_LOAD,
      ST_DIV,
      ST_UPDATE,
      ST_WALK_INIT,
      ST_WALK,
      ST_COMMIT,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic ram_write;
      logic res_hold;
      logic res_zero;
      logic tick_start;
      logic div_load;
      logic div_step;
      logic loop_update;
      logic walk_init;
      logic walk_step;
      logic commit;
      logic out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_load;
      logic active;
      logic single;
      logic div_last;
      logic play;
      logic walk_hit;
      logic walk_last;
      logic out_free;
   } ctrl_status_type;

endpackage

FILE: src/afs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module afs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/afs_ctrl.sv
// ----------------------------------------------------------------------------
// Animation frame selector controller
// Sequences one item at a time through decode, divide, table walk and
// result hand-off, driving the datapath by commands.
// ----------------------------------------------------------------------------
module afs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  afs_pkg::ctrl_status_type status,
   output afs_pkg::ctrl_cmd_type    cmd
);

   import afs_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_load || !status.active || status.single) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_WALK_INIT;
         end
         ST_WALK_INIT: begin
            state_in = status.play ? ST_WALK : ST_COMMIT;
         end
         ST_WALK: begin
            if (status.walk_hit || status.walk_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            if (status.is_load) begin
               cmd.ram_write = 1'b1;
               cmd.res_hold  = 1'b1;
            end else if (!status.active) begin
               cmd.res_hold = 1'b1;
            end else if (status.single) begin
               cmd.res_zero = 1'b1;
            end else begin
               cmd.tick_start = 1'b1;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_UPDATE: begin
            cmd.loop_update = 1'b1;
         end
         ST_WALK_INIT: begin
            cmd.walk_init = 1'b1;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         ST_RESP: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: src/afs_dp.sv
// ----------------------------------------------------------------------------
// Animation frame selector datapath
// Holds the duration table, the timing state, the speed multiplier, the
// serial divider, the duration walk and the result register.
// ----------------------------------------------------------------------------
module afs_dp #(
   parameter int MAX_FRAMES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  afs_pkg::ctrl_cmd_type    cmd,
   output afs_pkg::ctrl_status_type status,
   input  afs_pkg::cfg_type         cfg,
   input  afs_pkg::req_item_type    req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output afs_pkg::rsp_item_type    rsp_data
);

   import afs_pkg::*;

   localparam int AW = $clog2(MAX_FRAMES);
   localparam int CW = $clog2(MAX_FRAMES + 1);
   localparam int EW = (CW > FRAME_COUNT_W) ? CW : FRAME_COUNT_W;
   localparam int SW = DUR_W + AW;
   localparam int MW = (SW > TIME_W) ? SW : TIME_W;
   localparam int PW = TIME_W + SPEED_W;

   // Registers with reset.
   logic                   started_ff, started_in;
   logic [TIME_W-1:0]      start_time_ff, start_time_in;
   logic [TIME_W-1:0]      loops_seen_ff, loops_seen_in;
   logic                   shown_valid_ff, shown_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   req_item_type           req_ff, req_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic [TIME_W-1:0]      rem_ff, rem_in;
   logic [TIME_W-1:0]      quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [SW-1:0]          sum_ff, sum_in;
   logic [AW-1:0]          wk_ff, wk_in;
   logic [AW-1:0]          cur_ff, cur_in;
   logic [AW-1:0]          shown_ff, shown_in;
   logic [FRAME_IDX_W-1:0] res_frame_ff, res_frame_in;
   logic                   res_chg_ff, res_chg_in;
   rsp_item_type           rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic [EW-1:0]          count_ext;
   logic [CW-1:0]          count;
   logic                   active;
   logic                   animating;
   logic [TIME_W-1:0]      delta;
   logic [TIME_W-1:0]      elapsed;
   logic [TIME_W:0]        div_shift;
   logic [TIME_W:0]        div_trial;
   logic                   div_neg;
   logic [DUR_W-1:0]       ram_rdata;
   logic [AW-1:0]          ram_raddr;
   logic                   ram_we;
   logic [SW-1:0]          walk_sum;
   logic                   walk_hit;
   logic [AW:0]            wk_next_ext;
   logic [FRAME_IDX_W-1:0] shown_or_zero;
   logic                   cur_changed;

   // Frame count clamped to the table depth, and the activity flags.
   always_comb begin
      count_ext = EW'(cfg.frame_count);
      if (count_ext > EW'(MAX_FRAMES)) begin
         count_ext = EW'(MAX_FRAMES);
      end
   end
   assign count     = CW'(count_ext);
   assign active    = (count != '0) && (cfg.total_duration != '0);
   assign animating = (count >= CW'(2)) && (cfg.total_duration != '0);

   // Time since start; zero on the tick that latches the start time.
   assign delta = started_ff ? (req_ff.now_ms - start_time_ff) : '0;

   // Scaled time, saturated to 32 bits.
   assign elapsed = (prod_ff[PW-1:TIME_W+SPEED_FRAC_W] != '0) ? '1
                  : prod_ff[TIME_W+SPEED_FRAC_W-1:SPEED_FRAC_W];

   // One restoring divide step: remainder and quotient shift left by one bit.
   assign div_shift = {rem_ff, quo_ff[TIME_W-1]};
   assign div_trial = div_shift - {1'b0, cfg.total_duration};
   assign div_neg   = div_trial[TIME_W];

   // Duration table; entries past the table depth are dropped.
   assign ram_we    = cmd.ram_write && (32'(req_ff.entry_index) < 32'(MAX_FRAMES));
   assign wk_next_ext = {1'b0, wk_ff} + (AW + 1)'(1);
   assign ram_raddr = cmd.walk_init ? '0 : wk_next_ext[AW-1:0];

   afs_ram #(
      .WIDTH (DUR_W),
      .DEPTH (MAX_FRAMES)
   ) u_afs_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(req_ff.entry_index)),
      .wdata (req_ff.entry_duration),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Running sum of durations and the window test against the loop position.
   assign walk_sum = sum_ff + SW'(ram_rdata);
   assign walk_hit = MW'(rem_ff) < MW'(walk_sum);

   assign shown_or_zero = shown_valid_ff ? FRAME_IDX_W'(shown_ff) : '0;
   assign cur_changed   = !shown_valid_ff || (shown_ff != cur_ff);

   // Status to the controller.
   always_comb begin
      status           = '0;
      status.is_load   = (req_ff.req_type == REQ_LOAD);
      status.active    = active;
      status.single    = active && (count == CW'(1));
      status.div_last  = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
      status.play      = (cfg.loop_limit == '0)
                      || (loops_seen_ff < TIME_W'(cfg.loop_limit));
      status.walk_hit  = walk_hit;
      status.walk_last = (wk_next_ext == (AW + 1)'(count));
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Next values of all datapath registers.
   always_comb begin
      started_in     = started_ff;
      start_time_in  = start_time_ff;
      loops_seen_in  = loops_seen_ff;
      shown_valid_in = shown_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      req_in         = req_ff;
      prod_in        = prod_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      div_cnt_in     = div_cnt_ff;
      sum_in         = sum_ff;
      wk_in          = wk_ff;
      cur_in         = cur_ff;
      shown_in       = shown_ff;
      res_frame_in   = res_frame_ff;
      res_chg_in     = res_chg_ff;
      rsp_data_in    = rsp_data_ff;

      // Input transfer.
      if (cmd.capture) begin
         req_in = req_data;
      end

      // Results that need no timing work.
      if (cmd.res_hold) begin
         res_frame_in = shown_or_zero;
         res_chg_in   = 1'b0;
      end
      if (cmd.res_zero) begin
         res_frame_in = '0;
         res_chg_in   = 1'b0;
      end

      // First active tick latches the start time; the product is registered.
      if (cmd.tick_start) begin
         if (!started_ff) begin
            started_in    = 1'b1;
            start_time_in = req_ff.now_ms;
         end
         prod_in = PW'(delta) * PW'(cfg.speed_q8);
      end

      // Divider.
      if (cmd.div_load) begin
         rem_in     = '0;
         quo_in     = elapsed;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in     = div_neg ? div_shift[TIME_W-1:0] : div_trial[TIME_W-1:0];
         quo_in     = {quo_ff[TIME_W-2:0], !div_neg};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end

      // A new loop forgets the frame shown.
      if (cmd.loop_update) begin
         if (quo_ff > loops_seen_ff) begin
            loops_seen_in  = quo_ff;
            shown_valid_in = 1'b0;
         end
      end

      // Duration walk.
      if (cmd.walk_init) begin
         sum_in = '0;
         wk_in  = '0;
         cur_in = '0;
      end
      if (cmd.walk_step) begin
         sum_in = walk_sum;
         wk_in  = wk_next_ext[AW-1:0];
         if (walk_hit) begin
            cur_in = wk_ff;
         end
      end

      // Frame selection result.
      if (cmd.commit) begin
         res_frame_in = FRAME_IDX_W'(cur_ff);
         res_chg_in   = cur_changed;
         if (cur_changed) begin
            shown_valid_in = 1'b1;
            shown_in       = cur_ff;
         end
      end

      // Output register: a waiting result leaves on its transfer.
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.frame_index   = res_frame_ff;
         rsp_data_in.frame_changed = res_chg_ff;
         rsp_data_in.animating     = animating;
         rsp_data_in.loop_number   = loops_seen_ff;
      end
   end

   // Control and timing state.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         start_time_ff  <= '0;
         loops_seen_ff  <= '0;
         shown_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         started_ff     <= started_in;
         start_time_ff  <= start_time_in;
         loops_seen_ff  <= loops_seen_in;
         shown_valid_ff <= shown_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_cnt_ff   <= div_cnt_in;
      sum_ff       <= sum_in;
      wk_ff        <= wk_in;
      cur_ff       <= cur_in;
      shown_ff     <= shown_in;
      res_frame_ff <= res_frame_in;
      res_chg_ff   <= res_chg_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/animation_frame_selector.sv
// ----------------------------------------------------------------------------
// Animation frame selector
// Chooses the frame of a looping animation to display from a running
// millisecond time and a table of per-frame durations.
// ----------------------------------------------------------------------------
// Usage: the req channel carries load items, which write one frame duration,
// and tick items, which carry the current time. Every item gives exactly one
// item on the rsp channel. The csr port holds frame count, loop length, loop
// limit and Q8.8 speed; write it only while the block is idle.
// One item is processed at a time. A load item, or a tick while the
// animation is inactive or single-frame, goes from decode straight to the
// result hand-off. Any other tick runs the 32-step serial divider and then
// walks the durations (none once the loop limit is reached, else 1 to the
// frame count, at most MAX_FRAMES), one table read per cycle; the next item
// can be taken the cycle after the result is registered.
// Reset clears the start time, loop count and shown frame, returns the
// registers to their defaults; the duration table keeps its contents and
// needs no clearing.
// When the receiver stalls, the result waits in the output register; the
// block takes and processes the next item and holds its result until the
// register is free.
// ----------------------------------------------------------------------------
module animation_frame_selector #(
   parameter int MAX_FRAMES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  afs_pkg::req_item_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output afs_pkg::rsp_item_type         rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [afs_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [afs_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic [afs_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);

   import afs_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   csr_index_type   csr_index;
   logic            csr_write;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[PADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_COUNT:    cfg_in.frame_count    = csr_pwdata[FRAME_COUNT_W-1:0];
            CSR_TOTAL_DURATION: cfg_in.total_duration = csr_pwdata[TIME_W-1:0];
            CSR_LOOP_LIMIT:     cfg_in.loop_limit     = csr_pwdata[LOOP_LIMIT_W-1:0];
            CSR_SPEED_Q8:       cfg_in.speed_q8       = csr_pwdata[SPEED_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      unique case (csr_index)
         CSR_FRAME_COUNT:    csr_prdata = PDATA_W'(cfg_ff.frame_count);
         CSR_TOTAL_DURATION: csr_prdata = PDATA_W'(cfg_ff.total_duration);
         CSR_LOOP_LIMIT:     csr_prdata = PDATA_W'(cfg_ff.loop_limit);
         CSR_SPEED_Q8:       csr_prdata = PDATA_W'(cfg_ff.speed_q8);
         default:            csr_prdata = '0;
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_count    <= '0;
         cfg_ff.total_duration <= '0;
         cfg_ff.loop_limit     <= '0;
         cfg_ff.speed_q8       <= SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   afs_ctrl u_afs_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   afs_dp #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_afs_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/afs_checker.sv
// ----------------------------------------------------------------------------
// Animation frame selector checker
// Port-level properties of the frame selector, bound to its top level.
// ----------------------------------------------------------------------------
`include "animation_frame_selector_assert.svh"

module afs_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  afs_pkg::rsp_item_type rsp_data
);

   import afs_pkg::*;

   // A stalled result keeps its payload.
   `AFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Items are handled one at a time: the input closes after a transfer.
   `AFS_ASSERT_NEXT(a_req_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "input ready after a transfer")

   // Only an animating block reports a frame switch.
   `AFS_ASSERT_IMP(a_change_needs_anim, clock, reset, rsp_valid && rsp_data.frame_changed, rsp_data.animating, "frame switch while not animating")

   // The output is empty right after reset.
   `AFS_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind animation_frame_selector afs_checker u_afs_checker (.*);

FILE: tb/sv/animation_frame_selector_tb.sv
// ----------------------------------------------------------------------------
// Animation frame selector testbench
// Drives load and tick transfers through the request channel and compares
// every response with an in-bench frame selection model. Register settings
// are changed between phases while the block is idle and read back.
// ----------------------------------------------------------------------------
module animation_frame_selector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afs_pkg::*;

   localparam int FRAME_SLOTS = 64;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 100;
   localparam int DRAIN_WAIT  = 150;

   // Clock, reset and block ports.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_item_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_item_type         rsp_data;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [PADDR_W-1:0]   csr_paddr = '0;
   logic [PDATA_W-1:0]   csr_pwdata = '0;
   logic [PDATA_W-1:0]   csr_prdata;
   logic                 csr_pready;

   // Model copy of the registers.
   logic [FRAME_COUNT_W-1:0] cfg_frames = '0;
   logic [TIME_W-1:0]        cfg_total  = '0;
   logic [LOOP_LIMIT_W-1:0]  cfg_limit  = '0;
   logic [SPEED_W-1:0]       cfg_speed  = SPEED_RESET;

   // Model copy of the playback state.
   logic [DUR_W-1:0]       dur_tab [FRAME_SLOTS];
   logic                   has_started = 1'b0;
   logic [TIME_W-1:0]      t_start     = '0;
   logic [TIME_W-1:0]      loops_done  = '0;
   logic                   shown_ok    = 1'b0;
   logic [FRAME_IDX_W-1:0] shown_at    = '0;

   req_item_type req_backlog [$];
   rsp_item_type frames_due [$];
   int           errors   = 0;
   int           req_hold = 0;
   int           rsp_hold = 0;
   logic         calm     = 1'b0;

   animation_frame_selector #(
      .MAX_FRAMES(FRAME_SLOTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Prints one mismatch line and counts it.
   task automatic note_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
   endtask

   // Applies one accepted item to the model and returns the response it should give.
   function automatic rsp_item_type select_frame(input req_item_type it);
      rsp_item_type           r;
      logic [FRAME_COUNT_W-1:0] count;
      logic                   active;
      logic [FRAME_IDX_W-1:0] frame;
      logic                   changed;
      logic [TIME_W-1:0]      delta;
      logic [TIME_W-1:0]      elapsed;
      logic [TIME_W-1:0]      loop_n;
      logic [TIME_W-1:0]      pos;
      logic [63:0]            scaled;
      logic [63:0]            acc;
      logic [FRAME_IDX_W-1:0] cur;
      logic                   hit;
      count   = (cfg_frames > 7'(FRAME_SLOTS)) ? 7'(FRAME_SLOTS) : cfg_frames;
      active  = (count != '0) && (cfg_total != '0);
      frame   = shown_ok ? shown_at : '0;
      changed = 1'b0;
      if (it.req_type == REQ_LOAD) begin
         dur_tab[it.entry_index] = it.entry_duration;
      end else if (active && count == 7'd1) begin
         frame = '0;
      end else if (active) begin
         if (!has_started) begin
            has_started = 1'b1;
            t_start     = it.now_ms;
         end
         delta   = it.now_ms - t_start;
         scaled  = ({32'd0, delta} * {48'd0, cfg_speed}) >> SPEED_FRAC_W;
         elapsed = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
         loop_n  = elapsed / cfg_total;
         // A new loop forgets the frame on display.
         if (loop_n > loops_done) begin
            loops_done = loop_n;
            shown_ok   = 1'b0;
         end
         cur = '0;
         if (cfg_limit == '0 || loops_done < {16'd0, cfg_limit}) begin
            pos = elapsed % cfg_total;
            acc = '0;
            hit = 1'b0;
            for (int i = 0; i < FRAME_SLOTS; i++) begin
               if (!hit && i < int'(count)) begin
                  acc = acc + 64'(dur_tab[i]);
                  if ({32'd0, pos} < acc) begin
                     cur = 6'(i);
                     hit = 1'b1;
                  end
               end
            end
         end
         if (!shown_ok || shown_at != cur) begin
            shown_ok = 1'b1;
            shown_at = cur;
            changed  = 1'b1;
         end
         frame = cur;
      end
      r.frame_index   = frame;
      r.frame_changed = changed;
      r.animating     = (count >= 7'd2) && (cfg_total != '0);
      r.loop_number   = loops_done;
      return r;
   endfunction

   // Request driver: presents queued items with random idle bursts.
   always @(posedge clock) begin
      req_item_type nxt;
      logic         nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv  = req_valid;
         nxt = req_data;
         if (req_valid && req_ready) begin
            frames_due.push_back(select_frame(req_data));
            nv = 1'b0;
         end
         if (!nv) begin
            if (req_hold > 0) begin
               req_hold--;
            end else if (req_backlog.size() > 0) begin
               if (!calm && $urandom_range(0, 7) == 0) begin
                  req_hold = $urandom_range(1, 10) - 1;
               end else begin
                  nxt = req_backlog.pop_front();
                  nv  = 1'b1;
               end
            end
         end
         req_valid <= nv;
         req_data  <= nxt;
      end
   end

   // Response monitor: checks each transfer and stalls at random.
   always @(posedge clock) begin
      rsp_item_type want;
      logic         rdy;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frames_due.size() == 0) begin
               note_mismatch($sformatf("response %h with nothing expected", rsp_data));
            end else begin
               want = frames_due.pop_front();
               if (rsp_data.frame_index !== want.frame_index)
                  note_mismatch($sformatf("frame_index %h, want %h",
                                          rsp_data.frame_index, want.frame_index));
               if (rsp_data.frame_changed !== want.frame_changed)
                  note_mismatch($sformatf("frame_changed %b, want %b",
                                          rsp_data.frame_changed, want.frame_changed));
               if (rsp_data.animating !== want.animating)
                  note_mismatch($sformatf("animating %b, want %b",
                                          rsp_data.animating, want.animating));
               if (rsp_data.loop_number !== want.loop_number)
                  note_mismatch($sformatf("loop_number %h, want %h",
                                          rsp_data.loop_number, want.loop_number));
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rdy = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(1, 10) - 1;
            rdy      = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_ready <= rdy;
      end
   end

   // Register write: setup cycle, then access until pready.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_FRAME_COUNT:    cfg_frames = val[FRAME_COUNT_W-1:0];
         CSR_TOTAL_DURATION: cfg_total  = val;
         CSR_LOOP_LIMIT:     cfg_limit  = val[LOOP_LIMIT_W-1:0];
         CSR_SPEED_Q8:       cfg_speed  = val[SPEED_W-1:0];
         default: ;
      endcase
   endtask

   // Reads every register back and compares it with the model copy.
   task automatic check_regs();
      csr_index_type idx;
      logic [31:0]   want;
      idx = CSR_FRAME_COUNT;
      repeat (4) begin
         @(posedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         csr_paddr   <= {idx, 2'b00};
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         case (idx)
            CSR_FRAME_COUNT:    want = 32'(cfg_frames);
            CSR_TOTAL_DURATION: want = cfg_total;
            CSR_LOOP_LIMIT:     want = 32'(cfg_limit);
            default:            want = 32'(cfg_speed);
         endcase
         if (csr_prdata !== want)
            note_mismatch($sformatf("register %s reads %h, want %h",
                                    idx.name(), csr_prdata, want));
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         idx = idx.next();
      end
   endtask

   // Writes all four registers, junk above the narrow fields, then reads them back.
   task automatic program_regs(input logic [6:0] count, input logic [31:0] total,
                               input logic [15:0] limit, input logic [15:0] speed);
      write_reg(CSR_FRAME_COUNT, {25'($urandom()), count});
      write_reg(CSR_TOTAL_DURATION, total);
      write_reg(CSR_LOOP_LIMIT, {16'($urandom()), limit});
      write_reg(CSR_SPEED_Q8, {16'($urandom()), speed});
      check_regs();
   endtask

   // Waits until every queued item has been sent and answered.
   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || frames_due.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic push_tick(input logic [31:0] now);
      req_item_type it;
      it.req_type       = REQ_TICK;
      it.now_ms         = now;
      it.entry_index    = 6'($urandom());
      it.entry_duration = 24'($urandom());
      req_backlog.push_back(it);
   endtask

   task automatic push_load(input logic [5:0] idx, input logic [23:0] dur);
      req_item_type it;
      it.req_type       = REQ_LOAD;
      it.now_ms         = $urandom();
      it.entry_index    = idx;
      it.entry_duration = dur;
      req_backlog.push_back(it);
   endtask

   // Running sum of the first n durations in the model table.
   function automatic logic [31:0] sum_first(input int n);
      logic [31:0] acc;
      acc = '0;
      for (int i = 0; i < FRAME_SLOTS; i++)
         if (i < n) acc = acc + 32'(dur_tab[i]);
      return acc;
   endfunction

   // Stimulus sequence.
   initial begin
      logic [31:0] epoch;
      logic [31:0] play_ms;
      logic [31:0] s;
      logic [31:0] total;
      logic [31:0] base;
      logic [63:0] wide;
      logic [15:0] limit;
      logic [15:0] speed;
      logic [6:0]  count;
      logic [23:0] dur;
      int          pick;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_regs();

      // Nothing loaded: ticks leave the state alone, loads hit the table ends.
      push_tick($urandom());
      push_load(6'd0, 24'd0);
      push_load(6'd63, 24'hFF_FFFF);
      push_tick($urandom());

      // Fill the whole table so no unwritten entry is ever walked.
      for (int i = 0; i < FRAME_SLOTS; i++)
         push_load(6'(i), (i == 1) ? 24'd0 : 24'($urandom_range(1, 60)));
      wait_idle();

      // A single frame, then two inactive settings.
      program_regs(7'd1, 32'd100, 16'd0, 16'd256);
      push_tick($urandom());
      push_tick($urandom());
      wait_idle();
      program_regs(7'd0, 32'd1000, 16'd0, 16'd256);
      push_tick($urandom());
      wait_idle();
      program_regs(7'd3, 32'd0, 16'd0, 16'd256);
      push_tick($urandom());
      wait_idle();

      // Four frames with a zero-length second frame and a two-loop limit.
      s = sum_first(4);
      program_regs(7'd4, s, 16'd2, 16'd256);
      epoch = $urandom();
      push_tick(epoch);
      push_tick(epoch + 32'(dur_tab[0]));
      push_tick(epoch + s - 1);
      push_tick(epoch + s);
      push_tick(epoch + s);
      push_tick(epoch + 2 * s);
      push_tick(epoch + 2 * s + 32'(dur_tab[0]));

      // Largest duration in the last of three frames.
      push_load(6'd2, 24'hFF_FFFF);
      wait_idle();
      s = sum_first(3);
      program_regs(7'd3, s, 16'd0, 16'd256);
      push_tick(epoch + 3 * s + 32'(dur_tab[0]) + 5);
      push_tick(epoch + 4 * s - 1);
      wait_idle();

      // Oversized frame count, longest loop, speed extremes, saturation and wrap.
      program_regs(7'd127, 32'hFFFF_FFFF, 16'd0, 16'd65535);
      push_tick(epoch + 1);
      push_tick(epoch + 32'h0100_0000);
      wait_idle();
      write_reg(CSR_SPEED_Q8, 32'd0);
      push_tick(epoch + 12345);
      wait_idle();
      write_reg(CSR_SPEED_Q8, 32'd1);
      push_tick(epoch - 1);
      wait_idle();
      write_reg(CSR_SPEED_Q8, 32'd256);
      push_tick(epoch - 1);
      wait_idle();
      program_regs(7'd2, 32'd1, 16'd0, 16'd1);
      push_tick(epoch + 300);
      wait_idle();

      // Loop longer than the frames: the tail of the loop shows frame 0.
      s = sum_first(3);
      total = s + 1000;
      program_regs(7'd3, total, 16'd0, 16'd256);
      push_tick(epoch + 5 * total + s + 500);
      push_load(6'd2, 24'($urandom_range(1, 60)));
      wait_idle();

      // Random phases: mostly time moving forward through the loop.
      play_ms = '0;
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         if (ph == PHASES - 1) calm = 1'b1;
         pick = $urandom_range(0, 19);
         if (pick == 0)      count = 7'd0;
         else if (pick == 1) count = 7'd1;
         else if (pick == 2) count = 7'($urandom_range(65, 127));
         else if (pick < 6)  count = 7'd2;
         else if (pick < 9)  count = 7'd64;
         else                count = 7'($urandom_range(3, 63));
         s = sum_first((count > 7'd64) ? FRAME_SLOTS : int'(count));
         pick = $urandom_range(0, 9);
         if (pick == 0)      total = $urandom();
         else if (pick == 1) total = s + 32'($urandom_range(1, 500));
         else if (pick == 2) total = (s > 1) ? s / 2 : 32'd1;
         else                total = s;
         pick = $urandom_range(0, 9);
         if (pick < 5)       speed = 16'd256;
         else if (pick == 5) speed = 16'($urandom_range(1, 65535));
         else if (pick == 6) speed = 16'd128;
         else if (pick == 7) speed = 16'd512;
         else if (pick == 8) speed = 16'd65535;
         else                speed = 16'($urandom_range(1, 255));
         pick = $urandom_range(0, 9);
         if (pick < 5 || loops_done >= 32'd65530) limit = 16'd0;
         else if (pick < 8) limit = 16'(loops_done + $urandom_range(1, 5));
         else               limit = 16'($urandom_range(1, 65535));
         program_regs(count, total, limit, speed);

         // Step size moves the scaled time about a sixteenth of a loop.
         wide = (speed == 16'd0) ? 64'(total) : ((64'(total) << 4) / 64'(speed));
         if (wide < 64'd1) wide = 64'd1;
         if (wide > 64'h1000_0000) wide = 64'h1000_0000;
         base = wide[31:0];

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               pick = $urandom_range(0, 9);
               if (pick == 0)      dur = 24'd0;
               else if (pick == 1) dur = 24'($urandom_range(0, 24'hFF_FFFF));
               else                dur = 24'($urandom_range(1, 60));
               push_load(6'($urandom_range(0, 63)), dur);
            end else if (pick < 13 && ph >= PHASES / 2) begin
               push_tick($urandom());
            end else begin
               play_ms = play_ms + $urandom_range(0, 2 * base);
               push_tick(epoch + play_ms);
            end
         end
      end

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (frames_due.size() != 0)
         note_mismatch($sformatf("%0d responses never arrived", frames_due.size()));
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
